// File: src/tbcd_pkg.sv
// Shared types and constants for the text byte to character code decoder.
// No dependencies; used by every module of the block.
`default_nettype none

package tbcd_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CODE_W = 16;
  localparam int unsigned NEED_W = 2;
  localparam int unsigned ADDR_W = 3;

  localparam logic [ADDR_W-1:0] ADDR_ENCODING_MODE = 3'd0;

  localparam logic [MODE_W-1:0] MODE_RAW   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UTF8  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UCS2  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_UTF8;

  localparam logic [NEED_W-1:0] NEED_NONE = 2'd0;
  localparam logic [NEED_W-1:0] NEED_ONE  = 2'd1;
  localparam logic [NEED_W-1:0] NEED_TWO  = 2'd2;

  // One decoded character headed for the output register.
  typedef struct packed {
    logic              emit;
    logic [CODE_W-1:0] code;
    logic              last;
  } char_req_t;

endpackage

`default_nettype wire

// File: src/text_byte_to_codepoint_decoder.sv
// Top level of the text byte to character code decoder.
// Instantiates tbcd_cfg, tbcd_step and tbcd_out; depends on tbcd_pkg.
//
// Takes one text byte per cycle and gives 16-bit character codes: raw bytes
// (mode 0, also mode 3), lenient UTF-8 of up to three bytes (mode 1, the
// reset value) or big-endian UCS-2 pairs (mode 2), selected by the register
// at address 0. A byte is decoded in the cycle it is taken and its code, if
// any, appears in the output register in the following cycle; a new byte can be
// taken every cycle. The only limit on rate is the single output register:
// in_stall is high while that register holds a code that out_stall holds
// back. A byte marked last always yields a code marked last, with missing
// trailing bytes taken as zero. Change the mode only while idle.
`default_nettype none

module text_byte_to_codepoint_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [15:0] out_char_code,
  output logic             out_last_char
);

  logic [tbcd_pkg::MODE_W-1:0] mode;
  logic                        accept;
  logic                        busy;
  tbcd_pkg::char_req_t         req;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  tbcd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode    (mode)
  );

  tbcd_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .mode      (mode),
    .text_byte (in_text_byte),
    .last_byte (in_last_byte),
    .req       (req)
  );

  tbcd_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .req           (req),
    .busy          (busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

endmodule

`default_nettype wire

// File: src/tbcd_cfg.sv
// APB-style configuration register holding the encoding mode.
// Depends on tbcd_pkg.
`default_nettype none

module tbcd_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [2:0]                   paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output logic      [tbcd_pkg::MODE_W-1:0]  mode
);

  logic [tbcd_pkg::MODE_W-1:0] mode_r;
  logic [tbcd_pkg::MODE_W-1:0] mode_nxt;
  logic                        wr_en;
  logic                        sel_mode;

  assign sel_mode = (paddr[2] == tbcd_pkg::ADDR_ENCODING_MODE[2]);
  assign wr_en    = psel && penable && pwrite && sel_mode;

  always_comb begin
    mode_nxt = mode_r;
    if (wr_en) begin
      mode_nxt = pwdata[tbcd_pkg::MODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tbcd_pkg::MODE_RESET;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = sel_mode ? {{(32 - tbcd_pkg::MODE_W){1'b0}}, mode_r} : 32'd0;
  assign mode   = mode_r;

endmodule

`default_nettype wire

// File: src/tbcd_step.sv
// Per-byte decode: pending sequence state and the next-code logic.
// Depends on tbcd_pkg.
`default_nettype none

module tbcd_step (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic [tbcd_pkg::MODE_W-1:0]  mode,
  input  wire logic [tbcd_pkg::BYTE_W-1:0]  text_byte,
  input  wire logic                         last_byte,
  output tbcd_pkg::char_req_t               req
);

  logic [tbcd_pkg::NEED_W-1:0] need_r;
  logic [tbcd_pkg::NEED_W-1:0] need_nxt;
  logic [tbcd_pkg::CODE_W-1:0] part_r;
  logic [tbcd_pkg::CODE_W-1:0] part_nxt;

  logic [tbcd_pkg::NEED_W-1:0] need_dec;
  logic [tbcd_pkg::CODE_W-1:0] cont_code;
  logic                        emit;
  logic [tbcd_pkg::CODE_W-1:0] code;

  assign need_dec  = need_r - tbcd_pkg::NEED_ONE;
  assign cont_code = (need_r == tbcd_pkg::NEED_TWO)
                   ? (part_r | {4'd0, text_byte[5:0], 6'd0})
                   : (part_r | {10'd0, text_byte[5:0]});

  always_comb begin
    emit     = 1'b1;
    code     = {8'd0, text_byte};
    need_nxt = tbcd_pkg::NEED_NONE;
    part_nxt = '0;
    unique case (mode)
      tbcd_pkg::MODE_UTF8: begin
        if (need_r != tbcd_pkg::NEED_NONE) begin
          code     = cont_code;
          emit     = (need_dec == tbcd_pkg::NEED_NONE) || last_byte;
          need_nxt = need_dec;
          part_nxt = cont_code;
        end else if (text_byte[7:5] == 3'b110) begin
          code     = {5'd0, text_byte[4:0], 6'd0};
          emit     = last_byte;
          need_nxt = tbcd_pkg::NEED_ONE;
          part_nxt = code;
        end else if (text_byte[7:4] == 4'b1110) begin
          code     = {text_byte[3:0], 12'd0};
          emit     = last_byte;
          need_nxt = tbcd_pkg::NEED_TWO;
          part_nxt = code;
        end
      end
      tbcd_pkg::MODE_UCS2: begin
        if (need_r != tbcd_pkg::NEED_NONE) begin
          code = part_r | {8'd0, text_byte};
        end else begin
          code     = {text_byte, 8'd0};
          emit     = last_byte;
          need_nxt = tbcd_pkg::NEED_ONE;
          part_nxt = code;
        end
      end
      default: begin
      end
    endcase
    // any emitted code closes the pending sequence
    if (emit) begin
      need_nxt = tbcd_pkg::NEED_NONE;
      part_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= tbcd_pkg::NEED_NONE;
      part_r <= '0;
    end else if (accept) begin
      need_r <= need_nxt;
      part_r <= part_nxt;
    end
  end

  assign req.emit = emit;
  assign req.code = code;
  assign req.last = last_byte;

endmodule

`default_nettype wire

// File: src/tbcd_out.sv
// Result register with valid/stall handshake toward the consumer.
// Depends on tbcd_pkg.
`default_nettype none

module tbcd_out (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire tbcd_pkg::char_req_t          req,
  output logic                              busy,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [tbcd_pkg::CODE_W-1:0]  out_char_code,
  output logic                              out_last_char
);

  logic                        valid_r;
  logic                        valid_nxt;
  logic [tbcd_pkg::CODE_W-1:0] code_r;
  logic                        last_r;
  logic                        load;

  assign busy = valid_r && out_stall;
  assign load = accept && req.emit;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_r <= req.code;
      last_r <= req.last;
    end
  end

  assign out_valid     = valid_r;
  assign out_char_code = code_r;
  assign out_last_char = last_r;

endmodule

`default_nettype wire

// File: tb/sv/tbcd_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the text byte to character code decoder: follows the mode
// register and both request channels, predicts codes and compares them.
// Depends on tbcd_pkg.

module tbcd_checker #(
  parameter logic [2:0] MODE_ADDR = tbcd_pkg::ADDR_ENCODING_MODE
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  input  wire logic [31:0]                 prdata,
  input  wire logic                        pready,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic [tbcd_pkg::BYTE_W-1:0] in_text_byte,
  input  wire logic                        in_last_byte,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic [tbcd_pkg::CODE_W-1:0] out_char_code,
  input  wire logic                        out_last_char,
  output int unsigned                      fail_count,
  output int unsigned                      pending_codes,
  output int unsigned                      codes_checked
);

  typedef struct packed {
    logic [tbcd_pkg::CODE_W-1:0] code;
    logic                        last;
  } decoded_char_t;

  decoded_char_t               expected_chars[$];
  logic [tbcd_pkg::MODE_W-1:0] enc_mode;
  logic [tbcd_pkg::NEED_W-1:0] need;
  logic [tbcd_pkg::CODE_W-1:0] partial;

  function automatic void decode_text_byte(input logic [tbcd_pkg::BYTE_W-1:0] b,
                                           input logic lst);
    logic                        emit_now;
    logic [tbcd_pkg::CODE_W-1:0] code;
    emit_now = 1'b0;
    code     = '0;
    if (enc_mode == tbcd_pkg::MODE_UTF8) begin
      if (need != tbcd_pkg::NEED_NONE) begin
        partial = partial
                | ({10'b0, b[5:0]} << ((need == tbcd_pkg::NEED_TWO) ? 6 : 0));
        need    = need - 1'b1;
        if (need == tbcd_pkg::NEED_NONE || lst) begin
          emit_now = 1'b1;
          code     = partial;
        end
      end else if (b[7:5] == 3'b110) begin
        partial  = {5'b0, b[4:0], 6'b0};
        need     = tbcd_pkg::NEED_ONE;
        emit_now = lst;
        code     = partial;
      end else if (b[7:4] == 4'b1110) begin
        partial  = {b[3:0], 12'b0};
        need     = tbcd_pkg::NEED_TWO;
        emit_now = lst;
        code     = partial;
      end else begin
        emit_now = 1'b1;
        code     = {8'b0, b};
      end
    end else if (enc_mode == tbcd_pkg::MODE_UCS2) begin
      if (need != tbcd_pkg::NEED_NONE) begin
        emit_now = 1'b1;
        code     = partial | {8'b0, b};
      end else begin
        partial  = {b, 8'b0};
        need     = tbcd_pkg::NEED_ONE;
        emit_now = lst;
        code     = partial;
      end
    end else begin
      // raw and the spare mode: any pending code is dropped
      emit_now = 1'b1;
      code     = {8'b0, b};
    end
    if (emit_now) begin
      expected_chars.push_back('{code: code, last: lst});
      need    = tbcd_pkg::NEED_NONE;
      partial = '0;
    end
  endfunction

  always @(posedge clk) begin
    decoded_char_t exp_char;
    if (!rst_n) begin
      enc_mode = tbcd_pkg::MODE_RESET;
      need     = tbcd_pkg::NEED_NONE;
      partial  = '0;
      expected_chars.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected code %h last %b", $time, out_char_code, out_last_char);
          fail_count++;
        end else begin
          exp_char = expected_chars.pop_front();
          codes_checked++;
          if (out_char_code !== exp_char.code) begin
            $display("%0t: char_code expected %h got %h", $time, exp_char.code,
                     out_char_code);
            fail_count++;
          end
          if (out_last_char !== exp_char.last) begin
            $display("%0t: last_char expected %b got %b", $time, exp_char.last,
                     out_last_char);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        decode_text_byte(in_text_byte, in_last_byte);
      end
      if (psel && penable && pready && paddr == MODE_ADDR) begin
        if (pwrite) begin
          enc_mode = pwdata[tbcd_pkg::MODE_W-1:0];
        end else if (prdata !== {{(32 - tbcd_pkg::MODE_W){1'b0}}, enc_mode}) begin
          $display("%0t: encoding_mode read expected %h got %h", $time,
                   {{(32 - tbcd_pkg::MODE_W){1'b0}}, enc_mode}, prdata);
          fail_count++;
        end
      end
    end
    pending_codes = expected_chars.size();
  end

endmodule

// File: tb/sv/tb_text_byte_to_codepoint_decoder.sv
`timescale 1ns / 100ps
// Top of the decoder testbench: clock, reset, mode writes, byte requests and
// random stalls; depends on tbcd_pkg, tbcd_checker and the decoder RTL.

module tb_text_byte_to_codepoint_decoder;

  localparam logic [tbcd_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [15:0] out_char_code;
  logic        out_last_char;

  int unsigned fail_count;
  int unsigned pending_codes;
  int unsigned codes_checked;
  int unsigned bytes_sent = 0;
  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;
  int unsigned stall_left = 0;
  bit          quiet      = 1'b0;

  text_byte_to_codepoint_decoder u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  tbcd_checker #(.MODE_ADDR(tbcd_pkg::ADDR_ENCODING_MODE)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char),
    .fail_count   (fail_count),
    .pending_codes(pending_codes),
    .codes_checked(codes_checked)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    #3_000_000;
    $display("text_byte_to_codepoint_decoder regression: fail");
    $finish;
  end

  always @(negedge clk) begin
    if (stall_left != 0 && !quiet) begin
      out_stall  = 1'b1;
      stall_left = stall_left - 1;
    end else if (rst_n && !quiet && $urandom_range(0, 99) < stall_pct) begin
      out_stall  = 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall  = 1'b0;
      stall_left = 0;
    end
  end

  function automatic logic end_of_text();
    return $urandom_range(0, 19) == 0;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, 5);
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_text_byte = b;
    in_last_byte = lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending_codes != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic apb_request(input logic wr, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = tbcd_pkg::ADDR_ENCODING_MODE;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_mode(input logic [tbcd_pkg::MODE_W-1:0] m);
    apb_request(1'b1, {{(32 - tbcd_pkg::MODE_W){1'b0}}, m});
    apb_request(1'b0, '0);
  endtask

  task automatic send_utf8_request();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind) inside
      [0:2]: begin
        send_byte({1'b0, 7'($urandom)}, end_of_text());
      end
      [3:4]: begin
        send_byte({3'b110, 5'($urandom)}, end_of_text());
        send_byte({2'b10, 6'($urandom)}, end_of_text());
      end
      [5:6]: begin
        send_byte({4'b1110, 4'($urandom)}, end_of_text());
        send_byte({2'b10, 6'($urandom)}, end_of_text());
        send_byte({2'b10, 6'($urandom)}, end_of_text());
      end
      7: begin
        send_byte(8'($urandom), end_of_text());
      end
      8: begin
        // text ends right at or after a lead
        if ($urandom_range(0, 1) == 0) begin
          send_byte({3'b110, 5'($urandom)}, 1'b1);
        end else begin
          send_byte({4'b1110, 4'($urandom)}, 1'b0);
          send_byte({2'b10, 6'($urandom)}, 1'b1);
        end
      end
      default: begin
        // continuations with arbitrary values
        send_byte(8'($urandom_range(8'hc0, 8'hef)), 1'b0);
        send_byte(8'($urandom), end_of_text());
        send_byte(8'($urandom), end_of_text());
      end
    endcase
  endtask

  initial begin
    logic [tbcd_pkg::MODE_W-1:0] phase_modes[6];
    int unsigned                 pct_choice[3];
    int unsigned                 target;
    logic [tbcd_pkg::MODE_W-1:0] m;
    phase_modes = '{tbcd_pkg::MODE_UTF8, tbcd_pkg::MODE_UCS2, tbcd_pkg::MODE_RAW,
                    tbcd_pkg::MODE_UTF8, MODE_SPARE, tbcd_pkg::MODE_UCS2};
    pct_choice  = '{0, 15, 40};
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset mode is UTF-8
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hc3, 1'b0);
    send_byte(8'ha9, 1'b0);
    send_byte(8'he2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hac, 1'b0);
    send_byte(8'hc0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'he0, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h3f, 1'b0);
    send_byte(8'hf0, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hc5, 1'b1);
    send_byte(8'he1, 1'b0);
    send_byte(8'h80, 1'b1);
    drain();
    set_mode(tbcd_pkg::MODE_RAW);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();
    set_mode(tbcd_pkg::MODE_UCS2);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'hab, 1'b1);
    drain();
    set_mode(MODE_SPARE);
    send_byte(8'hc3, 1'b1);
    // mode changes with a code still pending
    drain();
    set_mode(tbcd_pkg::MODE_UTF8);
    send_byte(8'he2, 1'b0);
    drain();
    set_mode(tbcd_pkg::MODE_UCS2);
    send_byte(8'h41, 1'b0);
    send_byte(8'h12, 1'b0);
    drain();
    set_mode(tbcd_pkg::MODE_UTF8);
    send_byte(8'h80, 1'b0);
    send_byte(8'hc3, 1'b0);
    drain();
    set_mode(tbcd_pkg::MODE_RAW);
    send_byte(8'h41, 1'b1);

    for (int p = 0; p < 12; p++) begin
      drain();
      m = phase_modes[p % 6];
      set_mode(m);
      quiet     = (p == 11);
      gap_pct   = quiet ? 0 : pct_choice[$urandom_range(0, 2)];
      stall_pct = quiet ? 0 : pct_choice[$urandom_range(0, 2)];
      target    = bytes_sent + 120;
      while (bytes_sent < target) begin
        if (m == tbcd_pkg::MODE_UTF8) send_utf8_request();
        else send_byte(8'($urandom), end_of_text());
      end
    end

    drain();
    repeat (8) @(negedge clk);
    $display("covered %0d byte requests and %0d checked codes in raw, UTF-8, UCS-2", bytes_sent,
             codes_checked);
    $display("and spare modes, with mode changes mid-sequence and random stalls on both sides");
    if (fail_count == 0 && pending_codes == 0) begin
      $display("text_byte_to_codepoint_decoder regression: pass");
    end else begin
      $display("text_byte_to_codepoint_decoder regression: fail");
    end
    $finish;
  end

endmodule
